[rtl/bblur_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the border-aware 3x3 box blur.
package bblur_pkg;

    // Fixed field and register widths
    localparam int CFG_W      = 13;
    localparam int ROW_W      = 12;
    localparam int ROW_LIMIT  = 4096;
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    // Output queue
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // Averaging arithmetic: 9 x 255 fits in 12 bits, mean = (sum * recip) >> 15
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 15;
    localparam int CNT_W       = 4;

    // Neighbour counts of the clipped window
    localparam logic [CNT_W-1:0] CNT_ONE    = 4'd1;
    localparam logic [CNT_W-1:0] CNT_TWO    = 4'd2;
    localparam logic [CNT_W-1:0] CNT_THREE  = 4'd3;
    localparam logic [CNT_W-1:0] CNT_CORNER = 4'd4;
    localparam logic [CNT_W-1:0] CNT_EDGE   = 4'd6;
    localparam logic [CNT_W-1:0] CNT_INNER  = 4'd9;

    // Reciprocals scaled by 2^15, rounded up; exact for every sum up to 2295
    localparam logic [RECIP_W-1:0] RECIP_ONE    = 16'd32768;
    localparam logic [RECIP_W-1:0] RECIP_TWO    = 16'd16384;
    localparam logic [RECIP_W-1:0] RECIP_THREE  = 16'd10923;
    localparam logic [RECIP_W-1:0] RECIP_CORNER = 16'd8192;
    localparam logic [RECIP_W-1:0] RECIP_EDGE   = 16'd5462;
    localparam logic [RECIP_W-1:0] RECIP_INNER  = 16'd3641;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } t_kind;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Which sides of the window fall outside the frame
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edges;

    // Item as handed from the counters to the line stores
    typedef struct packed {
        logic   vld;
        logic   emit;
        logic   last;
        t_edges edges;
        t_rgb   pix;
    } t_item;

    // Tag that travels beside the window towards the averager
    typedef struct packed {
        logic   vld;
        logic   last;
        t_edges edges;
    } t_tag;

    typedef struct packed {
        t_rgb rgb;
        logic last;
    } t_res;

    // Scaled reciprocal of the number of in-frame neighbours
    function automatic logic [RECIP_W-1:0] recip_of(input t_edges e);
        logic [1:0]       rows;
        logic [1:0]       cols;
        logic [CNT_W-1:0] cnt;
        logic [RECIP_W-1:0] r;
        rows = 2'd3 - {1'b0, e.top} - {1'b0, e.bottom};
        cols = 2'd3 - {1'b0, e.left} - {1'b0, e.right};
        cnt  = {2'b00, rows} * {2'b00, cols};
        unique case (cnt)
            CNT_ONE:    r = RECIP_ONE;
            CNT_TWO:    r = RECIP_TWO;
            CNT_THREE:  r = RECIP_THREE;
            CNT_CORNER: r = RECIP_CORNER;
            CNT_EDGE:   r = RECIP_EDGE;
            CNT_INNER:  r = RECIP_INNER;
            default:    r = RECIP_ONE;
        endcase
        return r;
    endfunction

endpackage

[rtl/bblur_ctrl.sv]
`timescale 1ns / 1ps
// Frame registers, input/output position counters and item admission.
module bblur_ctrl
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_reg_idx         i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    input  logic             i_full,
    input  logic             i_kind,
    input  t_rgb             i_pix,
    output t_item            o_item,
    output logic [COL_W-1:0] o_col,
    output logic             o_restart
);

    localparam int EXT_W  = CFG_W + 1;
    localparam int IROW_W = ROW_W + 1;
    localparam int W_RST  = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

    logic [COL_W-1:0]  r_w_m1;
    logic [ROW_W-1:0]  r_h_m1;
    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [IROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;

    logic   flushing;
    logic   take;
    logic   emit;
    logic   in_end;
    logic   last;
    t_edges edges;

    // Clipped width - 1: zero acts as one, oversize as MAX_WIDTH
    function automatic logic [COL_W-1:0] width_m1(input logic [CFG_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = {1'b0, v};
        if (ext == '0) begin
            return '0;
        end else if (ext > EXT_W'(MAX_WIDTH)) begin
            return COL_W'(MAX_WIDTH - 1);
        end
        return COL_W'(ext - 1'b1);
    endfunction

    // Clipped height - 1: zero acts as one, oversize as the row limit
    function automatic logic [ROW_W-1:0] height_m1(input logic [CFG_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = {1'b0, v};
        if (ext == '0) begin
            return '0;
        end else if (ext > EXT_W'(ROW_LIMIT)) begin
            return ROW_W'(ROW_LIMIT - 1);
        end
        return ROW_W'(ext - 1'b1);
    endfunction

    // All pixels in: every item now flushes, drains are ignored before that
    assign flushing = r_in_row > {1'b0, r_h_m1};
    assign take     = i_valid && !i_full && !((i_kind == KIND_DRAIN) && !flushing);

    // Output trails input by one row and one pixel
    assign emit = (r_in_row >= IROW_W'(2)) ||
                  ((r_in_row == IROW_W'(1)) && (r_in_col != '0));
    assign in_end = r_in_col == r_w_m1;

    assign edges.top    = r_out_row == '0;
    assign edges.bottom = r_out_row == r_h_m1;
    assign edges.left   = r_out_col == '0;
    assign edges.right  = r_out_col == r_w_m1;
    assign last         = edges.bottom && edges.right;

    // Counter advance
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (take) begin
            if (in_end) begin
                n_in_col = '0;
                n_in_row = r_in_row + 1'b1;
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
            if (emit) begin
                priority if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (edges.right) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 1'b1;
                end else begin
                    n_out_col = r_out_col + 1'b1;
                end
            end
        end
    end

    // Registers; a register write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_m1    <= COL_W'(W_RST - 1);
            r_h_m1    <= ROW_W'(HEIGHT_RST - 1);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_w_m1 <= width_m1(i_cfg_data);
                REG_HEIGHT: r_h_m1 <= height_m1(i_cfg_data);
            endcase
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    assign o_item.vld   = take;
    assign o_item.emit  = emit;
    assign o_item.last  = last;
    assign o_item.edges = edges;
    assign o_item.pix   = flushing ? '0 : i_pix;
    assign o_col        = r_in_col;
    assign o_restart    = i_cfg_we;

`ifndef ASSERT_OFF
    // The frame's final result sends every counter back to the start
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && emit && last) |=>
        (r_in_col == '0 && r_in_row == '0 && r_out_col == '0 && r_out_row == '0))
        else $error("counters not cleared after last of frame");

    // Columns stay inside the configured width
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_col <= r_w_m1) && (r_out_col <= r_w_m1))
        else $error("column counter beyond frame width");
`endif

endmodule

[rtl/bblur_win.sv]
`timescale 1ns / 1ps
// Two line-store memories with read-modify-write, forwarding and the 3x3 window.
module bblur_win
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_item                 i_item,
    input  logic [COL_W-1:0]      i_col,
    input  logic                  i_restart,
    output t_rgb [2:0][2:0]       o_win,
    output t_tag                  o_tag
);

    // Line stores: upper holds row r-2, middle row r-1 at each column
    t_rgb r_mem_upper [MAX_WIDTH];
    t_rgb r_mem_mid   [MAX_WIDTH];
    t_rgb r_rd_upper;
    t_rgb r_rd_mid;

    // Read stage
    logic             r_s1_vld;
    logic             r_s1_fwd;
    logic [COL_W-1:0] r_s1_col;
    t_rgb             r_s1_pix;
    logic             r_s1_emit;
    logic             r_s1_last;
    t_edges           r_s1_edges;

    // Last values written, for a read that raced the write to its entry
    t_rgb r_fw_mid;
    t_rgb r_fw_pix;

    t_rgb            col_up;
    t_rgb            col_mid;
    t_rgb [2:0][2:0] r_win;
    logic            r_tag_vld;
    logic            r_tag_last;
    t_edges          r_tag_edges;

    // Memories: read at admission, written back in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_item.vld) begin
            r_rd_upper <= r_mem_upper[i_col];
            r_rd_mid   <= r_mem_mid[i_col];
        end
        if (r_s1_vld) begin
            r_mem_upper[r_s1_col] <= col_mid;
            r_mem_mid[r_s1_col]   <= r_s1_pix;
        end
    end

    // Same column back to back (one-pixel-wide frame): take the pending write
    assign col_up  = r_s1_fwd ? r_fw_mid : r_rd_upper;
    assign col_mid = r_s1_fwd ? r_fw_pix : r_rd_mid;

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_fwd  <= 1'b0;
            r_tag_vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_item.vld;
            r_s1_fwd  <= i_item.vld && r_s1_vld && (r_s1_col == i_col);
            r_tag_vld <= r_s1_vld && r_s1_emit;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_item.vld) begin
            r_s1_col   <= i_col;
            r_s1_pix   <= i_item.pix;
            r_s1_emit  <= i_item.emit;
            r_s1_last  <= i_item.last;
            r_s1_edges <= i_item.edges;
        end
        if (r_s1_vld) begin
            r_fw_mid    <= col_mid;
            r_fw_pix    <= r_s1_pix;
            r_tag_last  <= r_s1_last;
            r_tag_edges <= r_s1_edges;
        end
    end

    // Window shifts left; newest column enters on the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_win <= '0;
        end else if (r_s1_vld) begin
            for (int dr = 0; dr < 3; dr++) begin
                r_win[dr][0] <= r_win[dr][1];
                r_win[dr][1] <= r_win[dr][2];
            end
            r_win[0][2] <= col_up;
            r_win[1][2] <= col_mid;
            r_win[2][2] <= r_s1_pix;
        end
    end

    assign o_win       = r_win;
    assign o_tag.vld   = r_tag_vld;
    assign o_tag.last  = r_tag_last;
    assign o_tag.edges = r_tag_edges;

`ifndef ASSERT_OFF
    // Forwarding only follows an item that was writing in the cycle before
    a_fwd_follows_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> (r_s1_vld && $past(r_s1_vld)))
        else $error("forward selected without a preceding write");
`endif

endmodule

[rtl/bblur_avg.sv]
`timescale 1ns / 1ps
// Clipped neighbourhood sums and division by the neighbour count.
module bblur_avg
    import bblur_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_rgb [2:0][2:0] i_win,
    input  t_tag            i_tag,
    output logic            o_push,
    output t_res            o_res
);

    localparam int ROWSUM_W = 10;
    localparam int PROD_W   = SUM_W + RECIP_W;

    logic                      keep [3][3];
    logic [2:0][7:0]           chans [3][3];
    logic [7:0]                tap [3][3][3];
    logic [ROWSUM_W-1:0]       row_sum [3][3];
    logic [SUM_W-1:0]          tot [3];

    logic                      r_s3_vld;
    logic                      r_s3_last;
    logic [SUM_W-1:0]          r_s3_sum [3];
    logic [RECIP_W-1:0]        r_s3_recip;
    logic [PROD_W-1:0]         prod [3];
    logic [2:0][7:0]           quot;

    // Mask taps outside the frame, channel index 2 = red
    always_comb begin
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                keep[dr][dc] = !((dr == 0 && i_tag.edges.top)  ||
                                 (dr == 2 && i_tag.edges.bottom) ||
                                 (dc == 0 && i_tag.edges.left) ||
                                 (dc == 2 && i_tag.edges.right));
                chans[dr][dc] = i_win[dr][dc];
                for (int ch = 0; ch < 3; ch++) begin
                    tap[ch][dr][dc] = keep[dr][dc] ? chans[dr][dc][ch] : 8'd0;
                end
            end
        end
    end

    // Row sums, then the column of row sums
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int dr = 0; dr < 3; dr++) begin
                row_sum[ch][dr] = ROWSUM_W'(tap[ch][dr][0]) +
                                  ROWSUM_W'(tap[ch][dr][1]) +
                                  ROWSUM_W'(tap[ch][dr][2]);
            end
            tot[ch] = SUM_W'(row_sum[ch][0]) + SUM_W'(row_sum[ch][1]) +
                      SUM_W'(row_sum[ch][2]);
        end
    end

    // Sum stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= i_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tag.vld) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_s3_sum[ch] <= tot[ch];
            end
            r_s3_recip <= recip_of(i_tag.edges);
            r_s3_last  <= i_tag.last;
        end
    end

    // Reciprocal multiply; the queue entry registers the product
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = {{RECIP_W{1'b0}}, r_s3_sum[ch]} * {{SUM_W{1'b0}}, r_s3_recip};
            quot[ch] = prod[ch][RECIP_SHIFT +: 8];
        end
    end

    assign o_push       = r_s3_vld;
    assign o_res.rgb    = quot;
    assign o_res.last   = r_s3_last;

endmodule

[rtl/bblur_oq.sv]
`timescale 1ns / 1ps
// Output queue with credit count so the input never overruns it.
module bblur_oq
    import bblur_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_reserve,
    input  logic i_push,
    input  t_res i_res,
    output logic o_full,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    t_res                r_q [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr_ptr;
    logic [OQ_PTR_W-1:0] r_rd_ptr;
    logic [OQ_CNT_W-1:0] r_count;
    logic [OQ_CNT_W-1:0] r_pending;
    logic                pop;

    assign pop = o_valid && !i_stall;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    // Pointers, fill level and results promised but not yet taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
            r_pending <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
            if (i_reserve && !pop) begin
                r_pending <= r_pending + 1'b1;
            end else if (pop && !i_reserve) begin
                r_pending <= r_pending - 1'b1;
            end
        end
    end

    assign o_full  = r_pending >= OQ_CNT_W'(OQ_DEPTH);
    assign o_valid = r_count != '0;
    assign o_res   = r_q[r_rd_ptr];

`ifndef ASSERT_OFF
    // Every queued result was reserved at admission
    a_count_covered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_pending)
        else $error("queue holds more results than were reserved");

    // The credit scheme keeps a free slot for every push
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < OQ_CNT_W'(OQ_DEPTH)))
        else $error("push into a full output queue");
`endif

endmodule

[rtl/box_blur_3x3_border_average.sv]
`timescale 1ns / 1ps
// Top level of the border-aware 3x3 box blur.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------------
//   config   | i_cfg_we            | i_cfg_index, i_cfg_data (width, height)
//   input    | i_valid / o_stall   | i_kind, i_pixel_red/green/blue
//   output   | o_valid / i_stall   | o_out_red/green/blue, o_last_of_frame
//
// One item is taken every clock while o_stall is low; the item that completes a
// neighbourhood passes the memory read, window and sum registers before its result
// is presented (the output queue registers the product).
// The line stores are single-write, single-read memories; a one-pixel-wide frame
// hits the same entry on consecutive items and is served by forwarding.
// Reset needs no clearing pass: line-store entries are always written in a frame
// before any result uses them.
// o_stall rises only once eight results are owed (queued or in the pipeline).
module box_blur_3x3_border_average
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_reg_idx         i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_kind,
    input  logic [7:0]       i_pixel_red,
    input  logic [7:0]       i_pixel_green,
    input  logic [7:0]       i_pixel_blue,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    output logic             o_last_of_frame
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    t_rgb            pix_in;
    t_item           item;
    logic [COL_W-1:0] col;
    logic            restart;
    t_rgb [2:0][2:0] win;
    t_tag            tag;
    logic            push;
    t_res            res_in;
    t_res            res_out;
    logic            full;

    assign pix_in.red   = i_pixel_red;
    assign pix_in.green = i_pixel_green;
    assign pix_in.blue  = i_pixel_blue;

    // Position counters and frame registers
    bblur_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_full      (full),
        .i_kind      (i_kind),
        .i_pix       (pix_in),
        .o_item      (item),
        .o_col       (col),
        .o_restart   (restart)
    );

    // Line stores and window
    bblur_win #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_win (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item),
        .i_col     (col),
        .i_restart (restart),
        .o_win     (win),
        .o_tag     (tag)
    );

    // Neighbourhood mean
    bblur_avg u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (win),
        .i_tag   (tag),
        .o_push  (push),
        .o_res   (res_in)
    );

    // Output queue and input credit
    bblur_oq u_oq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reserve (item.vld && item.emit),
        .i_push    (push),
        .i_res     (res_in),
        .o_full    (full),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (res_out)
    );

    assign o_stall         = full;
    assign o_out_red       = res_out.rgb.red;
    assign o_out_green     = res_out.rgb.green;
    assign o_out_blue      = res_out.rgb.blue;
    assign o_last_of_frame = res_out.last;

endmodule

[tb/sv/tb_box_blur_3x3_border_average.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the border-aware 3x3 box blur: directed table, extreme settings, then random frames.
module tb_box_blur_3x3_border_average
    import bblur_pkg::*;
();

    localparam int MAX_W         = 4096;
    localparam int SETTLE        = 16;
    localparam int RANDOM_ITEMS  = 800;
    localparam int EXTREME_ITEMS = 40;
    localparam int DIR_ROWS      = 24;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET_WIDTH,
        ROW_SET_HEIGHT
    } t_row_op;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // One line of the directed table
    typedef struct packed {
        t_row_op          op;
        t_kind            kind;
        t_rgb             pix;
        logic [CFG_W-1:0] value;
        logic             typed;
        t_res             want;
    } t_row;

    logic             i_clk;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    t_reg_idx         i_cfg_index   = REG_WIDTH;
    logic [CFG_W-1:0] i_cfg_data    = '0;
    logic             i_valid       = 1'b0;
    logic             i_kind        = KIND_PIXEL;
    logic [7:0]       i_pixel_red   = '0;
    logic [7:0]       i_pixel_green = '0;
    logic [7:0]       i_pixel_blue  = '0;
    logic             i_stall       = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [7:0]       o_out_red;
    logic [7:0]       o_out_green;
    logic [7:0]       o_out_blue;
    logic             o_last_of_frame;

    box_blur_3x3_border_average #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_pixel_red    (i_pixel_red),
        .i_pixel_green  (i_pixel_green),
        .i_pixel_blue   (i_pixel_blue),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_last_of_frame(o_last_of_frame)
    );

    // Blur predictor state
    logic [23:0]      upper_line  [MAX_W];
    logic [23:0]      middle_line [MAX_W];
    logic [23:0]      blur_win    [9];
    int unsigned      in_col, in_row, out_col, out_row;
    logic [CFG_W-1:0] cfg_width  = CFG_W'(WIDTH_RST);
    logic [CFG_W-1:0] cfg_height = CFG_W'(HEIGHT_RST);
    t_res             blur_expected [$];

    int          fail_count = 0;
    int          stim_items = 0;
    int          burst_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    t_row        dir_rows [DIR_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Clipped frame dimension: 0 counts as 1, anything over the limit as the limit
    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] raw, input int unsigned lim);
        if (raw == 0) return 1;
        if (raw > lim) return lim;
        return 32'(raw);
    endfunction

    function automatic void restart_frame_model();
        for (int k = 0; k < 9; k++) blur_win[k] = '0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // Advance the predictor by one item; returns 1 when the item yields a blurred pixel
    function automatic bit blur_step(input t_kind kind, input t_rgb pix, output t_res res);
        int unsigned w, h, col, sr, sg, sb, cnt, k, dr, dc;
        logic [23:0] v, p;
        bit          flushing, emit;
        w        = eff_dim(cfg_width, MAX_W);
        h        = eff_dim(cfg_height, ROW_LIMIT);
        flushing = (in_row >= h);
        res      = '0;
        // drain ahead of the frame end does nothing
        if (kind == KIND_DRAIN && !flushing) return 1'b0;
        // once the frame is in, every item flushes with zero data
        v   = flushing ? 24'h0 : pix;
        col = (in_col >= MAX_W) ? 0 : in_col;
        for (k = 0; k < 3; k++) begin
            blur_win[k*3]   = blur_win[k*3+1];
            blur_win[k*3+1] = blur_win[k*3+2];
        end
        blur_win[2]      = upper_line[col];
        blur_win[5]      = middle_line[col];
        blur_win[8]      = v;
        upper_line[col]  = middle_line[col];
        middle_line[col] = v;
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
        end else begin
            in_col++;
        end
        if (!emit) return 1'b0;
        // mean over the neighbours that lie inside the frame
        sr  = 0;
        sg  = 0;
        sb  = 0;
        cnt = 0;
        for (dr = 0; dr < 3; dr++) begin
            for (dc = 0; dc < 3; dc++) begin
                if (!(dr == 0 && out_row == 0) && !(dr == 2 && out_row + 1 >= h) &&
                    !(dc == 0 && out_col == 0) && !(dc == 2 && out_col + 1 >= w)) begin
                    p = blur_win[dr*3+dc];
                    sr += p[23:16];
                    sg += p[15:8];
                    sb += p[7:0];
                    cnt++;
                end
            end
        end
        if (cnt == 0) cnt = 1;
        res.rgb.red   = 8'(sr / cnt);
        res.rgb.green = 8'(sg / cnt);
        res.rgb.blue  = 8'(sb / cnt);
        res.last      = (out_row + 1 >= h) && (out_col + 1 >= w);
        if (res.last) begin
            restart_frame_model();
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
        return 1'b1;
    endfunction

    function automatic t_row cfg_row(input t_row_op op, input logic [CFG_W-1:0] value);
        t_row r;
        r       = '0;
        r.op    = op;
        r.value = value;
        return r;
    endfunction

    function automatic t_row item_row(input t_kind kind, input logic [23:0] pix);
        t_row r;
        r      = '0;
        r.op   = ROW_ITEM;
        r.kind = kind;
        r.pix  = pix;
        return r;
    endfunction

    function automatic t_row typed_row(input t_kind kind, input logic [23:0] pix,
                                       input logic [23:0] want, input logic last);
        t_row r;
        r       = item_row(kind, pix);
        r.typed = 1'b1;
        r.want  = {want, last};
        return r;
    endfunction

    // Offer one item, honouring burst gaps, and record what it should yield
    task automatic push_item(input t_kind kind, input t_rgb pix, input bit typed, input t_res want);
        int   gap;
        t_res res;
        bit   produced;
        bit   live;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_pixel_red   <= pix.red;
        i_pixel_green <= pix.green;
        i_pixel_blue  <= pix.blue;
        do @(posedge i_clk); while (o_stall);
        live = (kind == KIND_PIXEL) || (in_row >= eff_dim(cfg_height, ROW_LIMIT));
        if (live) stim_items++;
        produced = blur_step(kind, pix, res);
        if (produced || typed) blur_expected.push_back(typed ? want : res);
    endtask

    task automatic send_random(input t_kind kind);
        t_rgb pix;
        case ($urandom_range(0, 7))
            0:       pix = 24'h000000;
            1:       pix = 24'hFFFFFF;
            default: pix = 24'($urandom_range(0, 24'hFFFFFF));
        endcase
        push_item(kind, pix, 1'b0, '0);
    endtask

    // Hold the sender off until every owed result is out and the pipeline is empty
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (blur_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_WIDTH) cfg_width = value;
        else cfg_height = value;
        // any write restarts the frame
        restart_frame_model();
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_drained();
        if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
        end else begin
            write_reg(REG_HEIGHT, h);
            write_reg(REG_WIDTH, w);
        end
    endtask

    // One whole frame: pixels (stray drains when noisy), then flush until the last result
    task automatic run_frame(input bit noisy);
        int unsigned h;
        h = eff_dim(cfg_height, ROW_LIMIT);
        while (in_row < h) begin
            if (noisy && $urandom_range(0, 9) == 0) send_random(KIND_DRAIN);
            else send_random(KIND_PIXEL);
        end
        while (in_row >= h) send_random(t_kind'($urandom_range(0, 1)));
    endtask

    function automatic logic [CFG_W-1:0] pick_dim(input int unsigned common_max,
                                                  input int unsigned rare_max);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7) return CFG_W'($urandom_range(1, common_max));
        if (r < 9) return CFG_W'($urandom_range(common_max + 1, rare_max));
        return CFG_W'($urandom_range(0, 1));
    endfunction

    // Receiver stall pattern, switching style every so often
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 300);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 7);
            default:     i_stall <= (stall_left % 5 < 2);
        endcase
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_res got;
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.rgb.red   = o_out_red;
            got.rgb.green = o_out_green;
            got.rgb.blue  = o_out_blue;
            got.last      = o_last_of_frame;
            if (blur_expected.size() == 0) begin
                fail_count++;
                $display("%0t: expected no result, got r=%02h g=%02h b=%02h last=%b",
                         $time, got.rgb.red, got.rgb.green, got.rgb.blue, got.last);
            end else begin
                want = blur_expected.pop_front();
                if (got !== want) begin
                    fail_count++;
                    $display("%0t: mismatch expected r=%02h g=%02h b=%02h last=%b,",
                             $time, want.rgb.red, want.rgb.green, want.rgb.blue,
                             want.last);
                    $display("%0t:          got      r=%02h g=%02h b=%02h last=%b",
                             $time, got.rgb.red, got.rgb.green, got.rgb.blue, got.last);
                end
            end
        end
    end

    // Watchdog
    initial begin
        #6_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int base;
        for (int k = 0; k < MAX_W; k++) begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
        end
        restart_frame_model();

        // directed table
        dir_rows[0]  = cfg_row(ROW_SET_WIDTH, 13'd0);
        dir_rows[1]  = cfg_row(ROW_SET_HEIGHT, 13'd0);
        dir_rows[2]  = item_row(KIND_DRAIN, 24'h000000);    // drain mid-frame: ignored
        dir_rows[3]  = item_row(KIND_PIXEL, 24'hFFFFFF);
        dir_rows[4]  = item_row(KIND_DRAIN, 24'h000000);
        dir_rows[5]  = typed_row(KIND_DRAIN, 24'h000000, 24'hFFFFFF, 1'b1);
        dir_rows[6]  = item_row(KIND_PIXEL, 24'h000000);
        dir_rows[7]  = item_row(KIND_PIXEL, 24'hFFFFFF);    // after the frame: acts as a drain
        dir_rows[8]  = typed_row(KIND_DRAIN, 24'h000000, 24'h000000, 1'b1);
        dir_rows[9]  = cfg_row(ROW_SET_WIDTH, 13'd2);
        dir_rows[10] = cfg_row(ROW_SET_HEIGHT, 13'd2);
        dir_rows[11] = item_row(KIND_PIXEL, 24'hFF0007);
        dir_rows[12] = item_row(KIND_PIXEL, 24'h01FF00);
        dir_rows[13] = item_row(KIND_PIXEL, 24'h0001FF);
        dir_rows[14] = item_row(KIND_PIXEL, 24'hFFFFFF);
        dir_rows[15] = item_row(KIND_DRAIN, 24'h000000);
        dir_rows[16] = item_row(KIND_DRAIN, 24'h000000);
        dir_rows[17] = item_row(KIND_DRAIN, 24'h000000);
        dir_rows[18] = cfg_row(ROW_SET_WIDTH, 13'd3);
        dir_rows[19] = cfg_row(ROW_SET_HEIGHT, 13'd3);
        dir_rows[20] = item_row(KIND_PIXEL, 24'h808080);
        dir_rows[21] = item_row(KIND_PIXEL, 24'h7F7F7F);
        dir_rows[22] = cfg_row(ROW_SET_HEIGHT, 13'h1FFF); // restart part-way through a frame
        dir_rows[23] = cfg_row(ROW_SET_HEIGHT, 13'd3);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            case (dir_rows[i].op)
                ROW_SET_WIDTH: begin
                    wait_drained();
                    write_reg(REG_WIDTH, dir_rows[i].value);
                end
                ROW_SET_HEIGHT: begin
                    wait_drained();
                    write_reg(REG_HEIGHT, dir_rows[i].value);
                end
                default: begin
                    push_item(dir_rows[i].kind, dir_rows[i].pix, dir_rows[i].typed,
                              dir_rows[i].want);
                end
            endcase
        end

        // widest and tallest settings, one pixel across the other way, cut short
        configure(13'h1FFF, 13'd1);
        repeat (EXTREME_ITEMS) send_random(KIND_PIXEL);
        configure(13'd1, 13'h1FFF);
        repeat (EXTREME_ITEMS) send_random(t_kind'($urandom_range(0, 1)));

        // random frames, some cut short
        base = stim_items;
        while (stim_items < base + RANDOM_ITEMS) begin
            configure(pick_dim(8, 24), pick_dim(5, 10));
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(0, 2 * eff_dim(cfg_width, MAX_W) *
                                          eff_dim(cfg_height, ROW_LIMIT)))
                    send_random(t_kind'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 3)) run_frame($urandom_range(0, 2) == 0);
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
